### design/afe_pkg.sv
// Shared types, constants and helper functions of the audio frame feature extractor.
// Used by afe_ctrl, afe_dp and audio_frame_feature_extractor_core; no dependencies.
package afe_pkg;

   localparam int MAX_FRAME_SAMPLES_DEF = 4096;
   localparam int MAX_FFT_SIZE_DEF      = 8192;

   localparam int SR_W       = 18;
   localparam int FFT_W      = 14;
   localparam int SQ_W       = 43;
   localparam int PEAK_W     = 16;
   localparam int BIN_W      = 14;
   localparam int BEST_W     = 13;
   localparam int MAG_W      = 24;
   localparam int WSUM_W     = 50;
   localparam int MSUM_W     = 37;
   localparam int WPROD_W    = 37;
   localparam int NUM_W      = 68;
   localparam int DEN_W      = 51;
   localparam int MP_W       = 18;
   localparam int ROOT_W     = 44;
   localparam int CNT_W      = 7;
   localparam int HZ_W       = 17;
   localparam int RMS_W      = 16;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 96;

   localparam logic [CNT_W-1:0]  DIV_STEPS  = 7'd68;
   localparam logic [CNT_W-1:0]  MUL_STEPS  = 7'd18;
   localparam logic [CNT_W-1:0]  ROOT_STEPS = 7'd22;
   localparam logic [ROOT_W-1:0] ROOT_TOP   = 44'h400_0000_0000;
   localparam logic [BIN_W-1:0]  BIN_LAST   = 14'd8191;
   localparam logic [BIN_W-1:0]  BIN_SAT    = 14'd8192;
   localparam logic [SR_W-1:0]   SR_RESET   = 18'd48000;
   localparam logic [FFT_W-1:0]  FFT_RESET  = 14'd4096;

   typedef enum logic [2:0] {
      OP_DIV_RMS,
      OP_SQRT,
      OP_MUL_PF,
      OP_DIV_PF,
      OP_MUL_CN,
      OP_MUL_CD,
      OP_DIV_CEN
   } op_type;

   typedef enum logic [1:0] {
      ST_ACC,
      ST_START,
      ST_WAIT,
      ST_OUT
   } state_type;

   typedef enum logic {
      CSR_SAMPLE_RATE = 1'b0,
      CSR_FFT_SIZE    = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic   accept;
      logic   start;
      op_type op;
      logic   emit;
   } ctl_cmd_type;

   typedef struct packed {
      logic busy;
      logic out_full;
   } dp_status_type;

   function automatic op_type next_op(input op_type op);
      op_type nxt;
      case (op)
         OP_DIV_RMS: nxt = OP_SQRT;
         OP_SQRT:    nxt = OP_MUL_PF;
         OP_MUL_PF:  nxt = OP_DIV_PF;
         OP_DIV_PF:  nxt = OP_MUL_CN;
         OP_MUL_CN:  nxt = OP_MUL_CD;
         OP_MUL_CD:  nxt = OP_DIV_CEN;
         default:    nxt = OP_DIV_CEN;
      endcase
      return nxt;
   endfunction

   function automatic logic [CNT_W-1:0] op_steps(input op_type op);
      logic [CNT_W-1:0] n;
      case (op)
         OP_SQRT:                        n = ROOT_STEPS;
         OP_MUL_PF, OP_MUL_CN, OP_MUL_CD: n = MUL_STEPS;
         default:                        n = DIV_STEPS;
      endcase
      return n;
   endfunction

endpackage

### design/audio_frame_feature_extractor_core.sv
// Samples and spectrum bins are taken at one transfer per clock while a frame streams in;
// the transfer with tlast closes the frame. The closing work then runs on one shared serial
// unit set: a restoring divide and a square root for the RMS level, a multiply and a divide
// for the peak frequency, and two multiplies and a divide for the centroid. The controller
// sequences the seven operations in turn and then loads the output register; no new
// transfer is taken while a frame closes. The finished result sits in an output register,
// so the next frame may start streaming while it waits to be taken.
module audio_frame_feature_extractor_core import afe_pkg::*; #(
   parameter int MAX_FRAME_SAMPLES = MAX_FRAME_SAMPLES_DEF,
   parameter int MAX_FFT_SIZE      = MAX_FFT_SIZE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // sample[15:0], magnitude[39:16]
   input  logic [0:0]            req_tuser,   // req_type[0]
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // rms_level[15:0], peak_level[31:16], peak_freq_hz[48:32],
   // peak_magnitude[72:49], centroid_hz[89:73], zero fill[95:90]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [0:0]            rsp_tuser,   // spectrum_valid[0]
   input  logic                  csr_we,
   input  logic [0:0]            csr_index,
   input  logic [SR_W-1:0]       csr_wdata
);

   ctl_cmd_type   cmd;
   dp_status_type status;

   afe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   afe_dp #(
      .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES),
      .MAX_FFT_SIZE      (MAX_FFT_SIZE)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      status.busy |-> !req_tready)
      else $error("Input transfer possible while the arithmetic unit is busy.");

   a_emit_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !(rsp_tvalid && !rsp_tready))
      else $error("Result written over a pending output transfer.");

   a_emit_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_tvalid)
      else $error("Result was not presented after emit.");

endmodule

### design/afe_ctrl.sv
// Controller state machine of the audio frame feature extractor.
// Depends on afe_pkg; drives the command struct of afe_dp.
module afe_ctrl import afe_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_tlast,
   output logic          req_tready,
   input  dp_status_type status,
   output ctl_cmd_type   cmd
);

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACC;
         op_ff    <= OP_DIV_RMS;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      req_tready = 1'b0;
      cmd.accept = 1'b0;
      cmd.start  = 1'b0;
      cmd.op     = op_ff;
      cmd.emit   = 1'b0;
      case (state_ff)
         ST_ACC: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (req_tlast) begin
                  op_in    = OP_DIV_RMS;
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            cmd.start = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (!status.busy) begin
               if (op_ff == OP_DIV_CEN) begin
                  state_in = ST_OUT;
               end else begin
                  op_in    = next_op(op_ff);
                  state_in = ST_START;
               end
            end
         end
         ST_OUT: begin
            if (!status.out_full) begin
               cmd.emit = 1'b1;
               state_in = ST_ACC;
            end
         end
         default: state_in = ST_ACC;
      endcase
   end

endmodule

### design/afe_dp.sv
// Datapath of the audio frame feature extractor: frame accumulators, configuration,
// a shared serial multiplier, restoring divider, square root and the result register.
// Depends on afe_pkg; sequenced by afe_ctrl.
module afe_dp import afe_pkg::*; #(
   parameter int MAX_FRAME_SAMPLES = MAX_FRAME_SAMPLES_DEF,
   parameter int MAX_FFT_SIZE      = MAX_FFT_SIZE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctl_cmd_type           cmd,
   output dp_status_type         status,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [0:0]            req_tuser,
   input  logic                  csr_we,
   input  logic [0:0]            csr_index,
   input  logic [SR_W-1:0]       csr_wdata,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [0:0]            rsp_tuser
);

   localparam int TOTAL_W = $clog2(MAX_FRAME_SAMPLES + 1);
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = TOTAL_W'(MAX_FRAME_SAMPLES);
   localparam logic [16:0] LIMIT_CAP = 17'(MAX_FFT_SIZE / 2);

   logic [SR_W-1:0]    sr_ff, sr_in;
   logic [FFT_W-1:0]   fft_ff, fft_in;
   logic [SQ_W-1:0]    sq_ff, sq_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [PEAK_W-1:0]  peak_ff, peak_in;
   logic [BIN_W-1:0]   bin_ff, bin_in;
   logic [BEST_W-1:0]  best_bin_ff, best_bin_in;
   logic [MAG_W-1:0]   best_mag_ff, best_mag_in;
   logic [WSUM_W-1:0]  wsum_ff, wsum_in;
   logic [MSUM_W-1:0]  msum_ff, msum_in;
   logic               busy_ff, busy_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   op_type             op_ff, op_in;
   logic               out_valid_ff, out_valid_in;

   logic [NUM_W-1:0]   q_ff, q_in;
   logic [DEN_W-1:0]   rem_ff, rem_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [NUM_W-1:0]   mc_ff, mc_in;
   logic [MP_W-1:0]    mp_ff, mp_in;
   logic [NUM_W-1:0]   acc_ff, acc_in;
   logic [NUM_W-1:0]   cen_num_ff, cen_num_in;
   logic [ROOT_W-1:0]  v_ff, v_in;
   logic [ROOT_W-1:0]  res_ff, res_in;
   logic [ROOT_W-1:0]  bit_ff, bit_in;
   logic [HZ_W-1:0]    pf_res_ff, pf_res_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [0:0]         rsp_user_ff, rsp_user_in;

   logic signed [15:0] sample;
   logic [MAG_W-1:0]   magnitude;
   logic [PEAK_W-1:0]  abs_val;
   logic [31:0]        sq_term;
   logic [16:0]        half_fft;
   logic [16:0]        limit;
   logic               bin_use;
   logic [WPROD_W-1:0] wprod;
   logic [DEN_W:0]     div_trial;
   logic [ROOT_W:0]    root_trial;
   logic               spec_ok;
   logic [RMS_W-1:0]   rms_out;
   logic [HZ_W-1:0]    pf_out;
   logic [MAG_W-1:0]   pm_out;
   logic [HZ_W-1:0]    cen_out;

   assign sample     = req_tdata[15:0];
   assign magnitude  = req_tdata[39:16];
   assign abs_val    = sample[15] ? (~req_tdata[15:0] + 16'd1) : req_tdata[15:0];
   assign sq_term    = abs_val * abs_val;
   assign half_fft   = 17'(fft_ff >> 1);
   assign limit      = (half_fft < LIMIT_CAP) ? half_fft : LIMIT_CAP;
   assign bin_use    = (17'(bin_ff) <= limit) && (bin_ff <= BIN_LAST);
   assign wprod      = WPROD_W'(bin_ff[BEST_W-1:0]) * WPROD_W'(magnitude);
   assign div_trial  = {rem_ff, q_ff[NUM_W-1]};
   assign root_trial = {1'b0, res_ff} + {1'b0, bit_ff};

   assign spec_ok = (bin_ff != '0) && (sr_ff != '0) && (fft_ff != '0);
   assign rms_out = (total_ff != '0) ? res_ff[RMS_W-1:0] : '0;
   assign pf_out  = spec_ok ? pf_res_ff : '0;
   assign pm_out  = spec_ok ? best_mag_ff : '0;
   assign cen_out = (spec_ok && (msum_ff != '0)) ? q_ff[HZ_W-1:0] : '0;

   always_comb begin
      sr_in       = sr_ff;
      fft_in      = fft_ff;
      sq_in       = sq_ff;
      total_in    = total_ff;
      peak_in     = peak_ff;
      bin_in      = bin_ff;
      best_bin_in = best_bin_ff;
      best_mag_in = best_mag_ff;
      wsum_in     = wsum_ff;
      msum_in     = msum_ff;
      busy_in     = busy_ff;
      cnt_in      = cnt_ff;
      op_in       = op_ff;
      q_in        = q_ff;
      rem_in      = rem_ff;
      den_in      = den_ff;
      mc_in       = mc_ff;
      mp_in       = mp_ff;
      acc_in      = acc_ff;
      cen_num_in  = cen_num_ff;
      v_in        = v_ff;
      res_in      = res_ff;
      bit_in      = bit_ff;
      pf_res_in   = pf_res_ff;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      out_valid_in = rsp_tready ? 1'b0 : out_valid_ff;

      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_SAMPLE_RATE: sr_in  = csr_wdata;
            CSR_FFT_SIZE:    fft_in = csr_wdata[FFT_W-1:0];
            default:         sr_in  = sr_ff;
         endcase
      end

      if (cmd.accept) begin
         if (!req_tuser[0]) begin
            if (total_ff < TOTAL_MAX) begin
               sq_in    = sq_ff + SQ_W'(sq_term);
               total_in = total_ff + 1'b1;
               if (abs_val > peak_ff) begin
                  peak_in = abs_val;
               end
            end
         end else begin
            if (bin_use) begin
               if (magnitude > best_mag_ff) begin
                  best_mag_in = magnitude;
                  best_bin_in = bin_ff[BEST_W-1:0];
               end
               wsum_in = wsum_ff + WSUM_W'(wprod);
               msum_in = msum_ff + MSUM_W'(magnitude);
            end
            bin_in = (bin_ff < BIN_LAST) ? (bin_ff + 1'b1) : BIN_SAT;
         end
      end

      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = op_steps(cmd.op);
         op_in   = cmd.op;
         case (cmd.op)
            OP_DIV_RMS: begin
               q_in   = NUM_W'(sq_ff);
               den_in = DEN_W'(total_ff);
               rem_in = '0;
            end
            OP_SQRT: begin
               v_in   = q_ff[ROOT_W-1:0];
               res_in = '0;
               bit_in = ROOT_TOP;
            end
            OP_MUL_PF: begin
               mc_in  = NUM_W'(best_bin_ff);
               mp_in  = sr_ff;
               acc_in = '0;
            end
            OP_DIV_PF: begin
               q_in   = acc_ff;
               den_in = DEN_W'(fft_ff);
               rem_in = '0;
            end
            OP_MUL_CN: begin
               pf_res_in = q_ff[HZ_W-1:0];
               mc_in     = NUM_W'(wsum_ff);
               mp_in     = sr_ff;
               acc_in    = '0;
            end
            OP_MUL_CD: begin
               cen_num_in = acc_ff;
               mc_in      = NUM_W'(msum_ff);
               mp_in      = MP_W'(fft_ff);
               acc_in     = '0;
            end
            default: begin
               q_in   = cen_num_ff;
               den_in = acc_ff[DEN_W-1:0];
               rem_in = '0;
            end
         endcase
      end else if (busy_ff) begin
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != 7'd1);
         case (op_ff)
            OP_SQRT: begin
               if ({1'b0, v_ff} >= root_trial) begin
                  v_in   = ROOT_W'({1'b0, v_ff} - root_trial);
                  res_in = (res_ff >> 1) + bit_ff;
               end else begin
                  res_in = res_ff >> 1;
               end
               bit_in = bit_ff >> 2;
            end
            OP_MUL_PF, OP_MUL_CN, OP_MUL_CD: begin
               if (mp_ff[0]) begin
                  acc_in = acc_ff + mc_ff;
               end
               mc_in = mc_ff << 1;
               mp_in = mp_ff >> 1;
            end
            default: begin
               if (div_trial >= {1'b0, den_ff}) begin
                  rem_in = DEN_W'(div_trial - {1'b0, den_ff});
                  q_in   = {q_ff[NUM_W-2:0], 1'b1};
               end else begin
                  rem_in = div_trial[DEN_W-1:0];
                  q_in   = {q_ff[NUM_W-2:0], 1'b0};
               end
            end
         endcase
      end

      if (cmd.emit) begin
         out_valid_in = 1'b1;
         rsp_data_in  = {6'd0, cen_out, pm_out, pf_out, peak_ff, rms_out};
         rsp_user_in  = (bin_ff != '0);
         sq_in        = '0;
         total_in     = '0;
         peak_in      = '0;
         bin_in       = '0;
         best_bin_in  = '0;
         best_mag_in  = '0;
         wsum_in      = '0;
         msum_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sr_ff        <= SR_RESET;
         fft_ff       <= FFT_RESET;
         sq_ff        <= '0;
         total_ff     <= '0;
         peak_ff      <= '0;
         bin_ff       <= '0;
         best_bin_ff  <= '0;
         best_mag_ff  <= '0;
         wsum_ff      <= '0;
         msum_ff      <= '0;
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         op_ff        <= OP_DIV_RMS;
         out_valid_ff <= 1'b0;
      end else begin
         sr_ff        <= sr_in;
         fft_ff       <= fft_in;
         sq_ff        <= sq_in;
         total_ff     <= total_in;
         peak_ff      <= peak_in;
         bin_ff       <= bin_in;
         best_bin_ff  <= best_bin_in;
         best_mag_ff  <= best_mag_in;
         wsum_ff      <= wsum_in;
         msum_ff      <= msum_in;
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         op_ff        <= op_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff        <= q_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      mc_ff       <= mc_in;
      mp_ff       <= mp_in;
      acc_ff      <= acc_in;
      cen_num_ff  <= cen_num_in;
      v_ff        <= v_in;
      res_ff      <= res_in;
      bit_ff      <= bit_in;
      pf_res_ff   <= pf_res_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign status.busy     = busy_ff;
   assign status.out_full = out_valid_ff && !rsp_tready;
   assign rsp_tvalid      = out_valid_ff;
   assign rsp_tdata       = rsp_data_ff;
   assign rsp_tuser       = rsp_user_ff;

endmodule

### tb/sv/tb_audio_frame_feature_extractor_core.sv
// Self-checking testbench for audio_frame_feature_extractor_core: streams frames of samples
// and spectrum bins, predicts RMS, peak, spectral peak and centroid, and checks each result.
// Depends on afe_pkg and the core RTL only.
module tb_audio_frame_feature_extractor_core import afe_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 6000;
   localparam int RANDOM_ITEMS = 1300;
   localparam int LONG_SAMPLES = 200;
   localparam int LONG_BINS = 200;

   typedef enum bit {
      KIND_SAMPLE = 1'b0,
      KIND_BIN    = 1'b1
   } item_kind_type;

   typedef struct {
      logic [15:0] rms;
      logic [15:0] peak;
      logic [16:0] peak_hz;
      logic [23:0] peak_mag;
      logic [16:0] centroid;
      logic        valid;
   } features_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [0:0]            req_tuser;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]            rsp_tuser;
   logic                  csr_we;
   logic [0:0]            csr_index;
   logic [SR_W-1:0]       csr_wdata;

   // Predictor state: configuration and frame accumulators.
   logic [17:0] rate_hz;
   logic [13:0] fft_len;
   logic [42:0] square_acc;
   logic [12:0] sample_cnt;
   logic [15:0] peak_abs;
   logic [13:0] bin_pos;
   logic [12:0] best_bin;
   logic [23:0] best_mag;
   logic [49:0] weighted_acc;
   logic [36:0] mag_acc;

   features_type expected_features[$];
   int  mismatches;
   int  idle_cycles;
   int  hold_cycles;
   int  stall_cycles;
   int  items_sent;
   bit  calm;

   audio_frame_feature_extractor_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic [21:0] floor_sqrt(input logic [42:0] v);
      logic [21:0] r;
      logic [43:0] t;
      r = '0;
      for (int b = 21; b >= 0; b--) begin
         t = 44'(r | (22'd1 << b));
         if (t * t <= {1'b0, v}) begin
            r = t[21:0];
         end
      end
      return r;
   endfunction

   task automatic clear_frame();
      square_acc   = '0;
      sample_cnt   = '0;
      peak_abs     = '0;
      bin_pos      = '0;
      best_bin     = '0;
      best_mag     = '0;
      weighted_acc = '0;
      mag_acc      = '0;
   endtask

   task automatic predict_features(input item_kind_type kind, input logic [15:0] smp,
                                   input logic [23:0] mag, input logic last);
      logic [15:0]  a;
      logic [13:0]  lim;
      logic [21:0]  root;
      logic [127:0] num;
      logic [127:0] den;
      features_type f;
      if (kind == KIND_SAMPLE) begin
         a = smp[15] ? -smp : smp;
         if (sample_cnt < MAX_FRAME_SAMPLES_DEF) begin
            square_acc = square_acc + a * a;
            sample_cnt = sample_cnt + 13'd1;
            if (a > peak_abs) begin
               peak_abs = a;
            end
         end
      end else begin
         lim = fft_len >> 1;
         if (lim > MAX_FFT_SIZE_DEF / 2) begin
            lim = 14'(MAX_FFT_SIZE_DEF / 2);
         end
         if (bin_pos <= lim) begin
            if (mag > best_mag) begin
               best_mag = mag;
               best_bin = bin_pos[12:0];
            end
            weighted_acc = weighted_acc + bin_pos * mag;
            mag_acc = mag_acc + mag;
         end
         bin_pos = (bin_pos < BIN_LAST) ? bin_pos + 14'd1 : BIN_SAT;
      end
      if (last) begin
         f = '{default: '0};
         if (sample_cnt != 0) begin
            root = floor_sqrt(square_acc / sample_cnt);
            f.rms = root[15:0];
         end
         f.peak = peak_abs;
         f.valid = (bin_pos != 0);
         if (f.valid && rate_hz != 0 && fft_len != 0) begin
            num = 128'(best_bin);
            num = num * rate_hz / fft_len;
            f.peak_hz = num[16:0];
            f.peak_mag = best_mag;
            if (mag_acc != 0) begin
               num = 128'(weighted_acc);
               num = num * rate_hz;
               den = 128'(fft_len);
               den = den * mag_acc;
               num = num / den;
               f.centroid = num[16:0];
            end
         end
         expected_features.push_back(f);
         clear_frame();
      end
   endtask

   task automatic send_item(input item_kind_type kind, input logic [15:0] smp,
                            input logic [23:0] mag, input logic last);
      @(negedge clock);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tdata  = {mag, smp};
      req_tuser  = kind;
      req_tlast  = last;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_features(kind, smp, mag, last);
      items_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_features.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [17:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      if (idx == CSR_SAMPLE_RATE) begin
         rate_hz = value;
      end else begin
         fft_len = value[13:0];
      end
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   function automatic logic [23:0] rand_mag();
      return ($urandom_range(0, 2) == 0) ? 24'($urandom_range(0, 3)) : 24'($urandom);
   endfunction

   task automatic random_frame(input int len);
      item_kind_type k;
      for (int i = 0; i < len; i++) begin
         k = item_kind_type'($urandom_range(0, 1));
         send_item(k, 16'($urandom), rand_mag(), i == len - 1);
      end
   endtask

   task automatic test_default_extremes();
      send_item(KIND_SAMPLE, 16'h8000, 24'hFFFFFF, 1'b0);
      send_item(KIND_SAMPLE, 16'h7FFF, 24'h000000, 1'b0);
      send_item(KIND_SAMPLE, 16'hFFFF, 24'h123456, 1'b0);
      send_item(KIND_SAMPLE, 16'h0000, 24'hFFFFFF, 1'b0);
      send_item(KIND_BIN, 16'hFFFF, 24'h000000, 1'b0);
      send_item(KIND_BIN, 16'h8000, 24'hFFFFFF, 1'b0);
      send_item(KIND_BIN, 16'h1234, 24'hFFFFFF, 1'b0);
      send_item(KIND_BIN, 16'h0000, 24'h000001, 1'b1);
      drain();
   endtask

   task automatic test_frame_kinds();
      send_item(KIND_SAMPLE, 16'h4000, 24'hABCDEF, 1'b0);
      send_item(KIND_SAMPLE, 16'hC000, 24'h000000, 1'b1);
      send_item(KIND_BIN, 16'h7FFF, 24'h000010, 1'b0);
      send_item(KIND_BIN, 16'h0000, 24'h000020, 1'b1);
      send_item(KIND_BIN, 16'h0000, 24'h000000, 1'b0);
      send_item(KIND_BIN, 16'h0000, 24'h000000, 1'b0);
      send_item(KIND_SAMPLE, 16'h0001, 24'h000000, 1'b1);
      send_item(KIND_SAMPLE, 16'h8001, 24'h000000, 1'b1);
      send_item(KIND_BIN, 16'h0000, 24'h000005, 1'b1);
      drain();
   endtask

   task automatic test_config_extremes();
      logic [17:0] rates[6] = '{18'd0, 18'd1, 18'd192000, 18'h3FFFF, 18'd44100, 18'd8000};
      logic [17:0] sizes[7] = '{18'h3C000, 18'd1, 18'd2, 18'd8192, 18'h3FFFF, 18'd7, 18'd0};
      foreach (sizes[s]) begin
         write_reg(CSR_FFT_SIZE, sizes[s]);
         write_reg(CSR_SAMPLE_RATE, rates[s % 6]);
         random_frame($urandom_range(3, 14));
         for (int i = 0; i < 6; i++) begin
            send_item(KIND_BIN, 16'($urandom), rand_mag(), i == 5);
         end
         drain();
      end
   endtask

   task automatic test_long_frame();
      write_reg(CSR_SAMPLE_RATE, 18'd192000);
      write_reg(CSR_FFT_SIZE, 18'd256);
      for (int i = 0; i < LONG_SAMPLES; i++) begin
         send_item(KIND_SAMPLE, (i == LONG_SAMPLES - 50) ? 16'h8000 : 16'($urandom),
                   24'($urandom), 1'b0);
      end
      for (int i = 0; i < LONG_BINS; i++) begin
         send_item(KIND_BIN, 16'($urandom),
                   (i > 128) ? 24'hFFFFFF : 24'($urandom_range(0, 4095)),
                   i == LONG_BINS - 1);
      end
      drain();
   endtask

   task automatic test_backpressure();
      write_reg(CSR_FFT_SIZE, 18'd16);
      write_reg(CSR_SAMPLE_RATE, 18'd16000);
      hold_cycles = 1200;
      for (int n = 0; n < 4; n++) begin
         random_frame($urandom_range(2, 12));
      end
      drain();
   endtask

   task automatic test_random();
      int frames;
      frames = 0;
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (frames % 8 == 0) begin
            drain();
            write_reg(CSR_SAMPLE_RATE, ($urandom_range(0, 5) == 0) ?
                      18'($urandom) : 18'($urandom_range(1, 192000)));
            write_reg(CSR_FFT_SIZE, ($urandom_range(0, 4) == 0) ?
                      18'($urandom) : 18'($urandom_range(2, 40)));
         end
         if (items_sent > RANDOM_ITEMS - 250) begin
            calm = 1'b1;
         end
         random_frame($urandom_range(1, 24));
         frames++;
      end
      drain();
   endtask

   initial begin
      rsp_tready   = 1'b0;
      stall_cycles = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready = 1'b0;
         end else if (stall_cycles > 0) begin
            stall_cycles--;
            rsp_tready = 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_cycles = $urandom_range(0, 2);
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      features_type got;
      features_type want;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.rms      = rsp_tdata[15:0];
            got.peak     = rsp_tdata[31:16];
            got.peak_hz  = rsp_tdata[48:32];
            got.peak_mag = rsp_tdata[72:49];
            got.centroid = rsp_tdata[89:73];
            got.valid    = rsp_tuser[0];
            if (expected_features.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("Unexpected result transfer at %0t", $realtime);
               end
            end else begin
               want = expected_features.pop_front();
               if (got.rms !== want.rms || got.peak !== want.peak ||
                   got.peak_hz !== want.peak_hz || got.peak_mag !== want.peak_mag ||
                   got.centroid !== want.centroid || got.valid !== want.valid) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("Mismatch at %0t: rms %0d/%0d peak %0d/%0d pk_hz %0d/%0d",
                              $realtime, want.rms, got.rms, want.peak, got.peak,
                              want.peak_hz, got.peak_hz);
                     $display("   pk_mag %0d/%0d centroid %0d/%0d valid %0d/%0d",
                              want.peak_mag, got.peak_mag, want.centroid, got.centroid,
                              want.valid, got.valid);
                  end
               end
            end
         end
      end
   end

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      req_tlast   = 1'b0;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      mismatches  = 0;
      idle_cycles = 0;
      hold_cycles = 0;
      calm        = 1'b0;
      rate_hz     = SR_RESET;
      fft_len     = FFT_RESET;
      clear_frame();
      repeat (5) @(negedge clock);
      reset = 1'b0;
      test_default_extremes();
      test_frame_kinds();
      test_config_extremes();
      test_long_frame();
      test_backpressure();
      test_random();
      repeat (350) @(negedge clock);
      if (mismatches == 0 && expected_features.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
